// File: rtl/ffba_pkg.sv
`timescale 1ns / 1ps
package ffba_pkg;

  localparam int MaxBlocks = 64;
  localparam int IdxW = $clog2(MaxBlocks);
  localparam int CntW = $clog2(MaxBlocks + 1);

  localparam logic [2:0] ST_REUSED    = 3'd0;
  localparam logic [2:0] ST_NEW       = 3'd1;
  localparam logic [2:0] ST_FREED     = 3'd2;
  localparam logic [2:0] ST_NULL      = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_OVERFLOW  = 3'd5;
  localparam logic [2:0] ST_NOT_FOUND = 3'd6;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic REG_HEAP_BASE = 1'b0;
  localparam logic REG_HEADER    = 1'b1;

  // table entry: start, size, free flag
  localparam int EntW = 65;

  typedef struct packed {
    logic        action;
    logic [31:0] alloc_size;
    logic [31:0] user_address;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic [2:0]  status;
  } out_item_t;

  typedef struct packed {
    logic        load;       // capture input item
    logic        rd_en;      // note scan index of entry being read
    logic        cap_ent;    // capture entry returned by RAM
    logic        scan_inc;   // advance scan index
    logic        wr_hit;     // write modified hit entry
    logic        wr_new;     // append new entry
    logic        sh_wr;      // shift step write: entry[idx-1] <= rdata
    logic        dec_count;
    logic        set_result;
    logic [2:0]  result_status;
  } ctrl_t;

  typedef struct packed {
    logic       is_free_act;
    logic       addr_zero;
    logic       scan_done;   // scan index reached block_count
    logic       hit;         // registered entry matches
    logic       full;
    logic       overflow;
    logic       nxt_free;    // entry after hit is free
    logic       nxt_exists;
  } stat_t;

endpackage

// File: rtl/ffba_ram.sv
`timescale 1ns / 1ps
module ffba_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/ffba_ctrl.sv
`timescale 1ns / 1ps
module ffba_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  ffba_pkg::stat_t st,
  output ffba_pkg::ctrl_t ctl
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;  // read issued, data next cycle
  localparam logic [3:0] S_LATCH = 4'd2;  // register entry from RAM
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_NWAIT = 4'd4;  // neighbor read in flight
  localparam logic [3:0] S_NEXT  = 4'd5;  // check neighbor of freed entry
  localparam logic [3:0] S_SHRD  = 4'd6;  // shift: read entry at index
  localparam logic [3:0] S_SHWR  = 4'd7;  // shift: write it one slot down
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // sequencer
  always_comb begin
    ctl = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (st.is_free_act && st.addr_zero) begin
          ctl.set_result = 1'b1;
          ctl.result_status = ffba_pkg::ST_NULL;
          state_nxt = S_OUT;
        end else if (st.scan_done) begin
          ctl.set_result = 1'b1;
          if (st.is_free_act) begin
            ctl.result_status = ffba_pkg::ST_NOT_FOUND;
          end else if (st.full) begin
            ctl.result_status = ffba_pkg::ST_FULL;
          end else if (st.overflow) begin
            ctl.result_status = ffba_pkg::ST_OVERFLOW;
          end else begin
            ctl.result_status = ffba_pkg::ST_NEW;
            ctl.wr_new = 1'b1;
          end
          state_nxt = S_OUT;
        end else begin
          ctl.rd_en = 1'b1;
          state_nxt = S_LATCH;
        end
      end
      S_LATCH: begin
        ctl.cap_ent = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (st.hit) begin
          if (st.is_free_act) begin
            ctl.scan_inc = 1'b1;
            state_nxt = S_NWAIT;
          end else begin
            ctl.wr_hit = 1'b1;
            ctl.set_result = 1'b1;
            ctl.result_status = ffba_pkg::ST_REUSED;
            state_nxt = S_OUT;
          end
        end else begin
          ctl.scan_inc = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_NWAIT: begin
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        ctl.wr_hit = 1'b1;
        ctl.set_result = 1'b1;
        ctl.result_status = ffba_pkg::ST_FREED;
        if (st.nxt_exists && st.nxt_free) begin
          ctl.scan_inc = 1'b1;
          state_nxt = S_SHRD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_SHRD: begin
        if (st.scan_done) begin
          ctl.dec_count = 1'b1;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        ctl.sh_wr = 1'b1;
        ctl.scan_inc = 1'b1;
        state_nxt = S_SHRD;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

// File: rtl/ffba_dp.sv
`timescale 1ns / 1ps
module ffba_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  ffba_pkg::in_item_t  in_data,
  input  logic                cfg_valid,
  input  logic                cfg_index,
  input  logic                cfg_index_ok,
  input  logic [31:0]         cfg_data,
  input  ffba_pkg::ctrl_t     ctl,
  output ffba_pkg::stat_t     st,
  output ffba_pkg::out_item_t out_data
);
  localparam int IW = ffba_pkg::IdxW;
  localparam int CW = ffba_pkg::CntW;

  logic [7:0]  header_r;
  logic [32:0] heap_top_r;
  logic [CW-1:0] count_r;
  ffba_pkg::in_item_t item_r;
  logic [CW-1:0] idx_r;       // entry being read
  logic [CW-1:0] hit_idx_r;
  logic [ffba_pkg::EntW-1:0] hit_ent_r;
  ffba_pkg::out_item_t res_r;
  logic [31:0] head_r;        // header address sought by a free
  logic [33:0] new_top_r;

  logic we;
  logic [IW-1:0] waddr, raddr;
  logic [ffba_pkg::EntW-1:0] wdata, rdata;
  logic [31:0] r_start, r_size;
  logic r_free;
  logic [33:0] merged;
  logic [31:0] hit_size;

  assign r_start = rdata[64:33];
  assign r_size  = rdata[32:1];
  assign r_free  = rdata[0];

  ffba_ram #(.Width(ffba_pkg::EntW), .Depth(ffba_pkg::MaxBlocks)) u_tab (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign raddr = idx_r[IW-1:0];

  // merged size of freed entry and its free neighbor, saturating
  assign merged = {2'b0, hit_ent_r[32:1]} + {26'b0, header_r} + {2'b0, r_size};
  assign hit_size = (merged[33:32] != 2'b0) ? 32'hFFFF_FFFF : merged[31:0];

  // table write port
  always_comb begin
    we = 1'b0;
    waddr = hit_idx_r[IW-1:0];
    wdata = hit_ent_r;
    if (ctl.wr_new) begin
      we = 1'b1;
      waddr = count_r[IW-1:0];
      wdata = {heap_top_r[31:0], item_r.alloc_size, 1'b0};
    end else if (ctl.wr_hit) begin
      we = 1'b1;
      if (item_r.action == ffba_pkg::ACT_FREE) begin
        wdata = {hit_ent_r[64:33],
                 (st.nxt_exists && r_free) ? hit_size : hit_ent_r[32:1], 1'b1};
      end else begin
        wdata = {hit_ent_r[64:1], 1'b0};
      end
    end else if (ctl.sh_wr) begin
      we = 1'b1;
      waddr = IW'(idx_r - CW'(1));
      wdata = rdata;
    end
  end

  // status toward controller
  always_comb begin
    st.is_free_act = (item_r.action == ffba_pkg::ACT_FREE);
    st.addr_zero   = (item_r.user_address == 32'b0);
    st.scan_done   = (idx_r >= count_r);
    st.full        = (count_r == CW'(ffba_pkg::MaxBlocks));
    st.overflow    = (new_top_r[33:32] != 2'b0);
    st.nxt_free    = r_free;
    st.nxt_exists  = (idx_r < count_r);
    if (item_r.action == ffba_pkg::ACT_FREE) begin
      st.hit = (hit_ent_r[64:33] == head_r);
    end else begin
      st.hit = hit_ent_r[0] && (hit_ent_r[32:1] >= item_r.alloc_size);
    end
  end

  assign out_data = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r    <= 8'd12;
      heap_top_r  <= 33'd1048576;
      count_r     <= '0;
    end else begin
      if (cfg_valid && cfg_index_ok) begin
        if (cfg_index == ffba_pkg::REG_HEAP_BASE) begin
          if (count_r == '0) begin
            heap_top_r <= {1'b0, cfg_data};
          end
        end else begin
          header_r <= cfg_data[7:0];
        end
      end
      if (ctl.wr_new) begin
        count_r <= count_r + CW'(1);
        heap_top_r <= new_top_r[32:0];
      end
      if (ctl.dec_count) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  // item and scan datapath
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_r <= in_data;
      idx_r  <= '0;
      head_r <= in_data.user_address - {24'b0, header_r};
      new_top_r <= {1'b0, heap_top_r} + {26'b0, header_r} + {2'b0, in_data.alloc_size};
    end else if (ctl.scan_inc) begin
      idx_r <= idx_r + CW'(1);
    end
    if (ctl.rd_en && !ctl.scan_inc) begin
      hit_idx_r <= idx_r;
    end
    // entry read in the previous cycle
    if (ctl.cap_ent) begin
      hit_ent_r <= rdata;
    end
    if (ctl.set_result) begin
      res_r.status <= ctl.result_status;
      if (ctl.result_status == ffba_pkg::ST_REUSED) begin
        res_r.result_address <= hit_ent_r[64:33] + {24'b0, header_r};
      end else if (ctl.result_status == ffba_pkg::ST_NEW) begin
        res_r.result_address <= heap_top_r[31:0] + {24'b0, header_r};
      end else begin
        res_r.result_address <= 32'b0;
      end
    end
  end
endmodule

// File: rtl/first_fit_block_allocator_core.sv
`timescale 1ns / 1ps
// First-fit heap allocator over a 64-entry address-ordered block table held
// in a single-port-write RAM with registered read. Each item gives one
// result, and one item is handled at a time. Each table entry visited is
// read, registered and compared in turn. An allocate reuses the first free
// entry large enough, or else appends, finds the table full or overflows
// the heap after scanning every entry. A null free returns without a scan,
// and a free of an unknown address scans the whole table. A free that finds
// its entry then reads the next one, and when the next block is also free
// it merges the two and shifts the rest of the table down one entry at a
// time. The result then waits for out_ready, and the next item is taken in
// the cycle after the result handshake. Configuration writes are taken
// only while the block is idle.
module first_fit_block_allocator_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ffba_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ffba_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_index,
  input  logic [31:0]         cfg_data
);
  ffba_pkg::ctrl_t ctl;
  ffba_pkg::stat_t st;

  // register writes only with no item in flight or arriving
  assign cfg_ready = in_ready && !in_valid;

  ffba_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .st(st), .ctl(ctl)
  );

  ffba_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cfg_valid(cfg_valid && cfg_ready),
    .cfg_index(cfg_index[0]), .cfg_index_ok(cfg_index[31:1] == 31'b0),
    .cfg_data(cfg_data), .ctl(ctl), .st(st), .out_data(out_data)
  );
endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  // Allocator state kept by the testbench, with its own expected-result queue
  class alloc_scoreboard;
    bit [31:0] base_reg;
    bit [7:0]  hdr_reg;
    bit [31:0] blk_start [ffba_pkg::MaxBlocks];
    bit [31:0] blk_size [ffba_pkg::MaxBlocks];
    bit        blk_free [ffba_pkg::MaxBlocks];
    int unsigned blk_cnt;
    bit [32:0] top_addr;
    ffba_pkg::out_item_t pending_q[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned status_seen [8];

    function new();
      base_reg = 32'd1048576;
      hdr_reg = 8'd12;
      blk_cnt = 0;
      top_addr = {1'b0, base_reg};
      mismatches = 0;
      checked = 0;
    endfunction

    function void write_reg(bit [31:0] idx, bit [31:0] val);
      if (idx == 32'(ffba_pkg::REG_HEAP_BASE)) begin
        base_reg = val;
        if (blk_cnt == 0) top_addr = {1'b0, val};
      end else if (idx == 32'(ffba_pkg::REG_HEADER)) begin
        hdr_reg = val[7:0];
      end
    endfunction

    // Work out the result of one accepted item and queue it
    function void note_item(ffba_pkg::in_item_t it);
      ffba_pkg::out_item_t r;
      bit [33:0] nt;
      bit [31:0] head;
      bit [33:0] merged;
      int i;
      bit done;
      r = '0;
      done = 0;
      if (it.action == ffba_pkg::ACT_ALLOC) begin
        for (i = 0; i < blk_cnt && !done; i++) begin
          if (blk_free[i] && blk_size[i] >= it.alloc_size) begin
            blk_free[i] = 0;
            r.result_address = blk_start[i] + 32'(hdr_reg);
            r.status = ffba_pkg::ST_REUSED;
            done = 1;
          end
        end
        if (!done) begin
          nt = {1'b0, top_addr} + 34'(hdr_reg) + 34'(it.alloc_size);
          if (blk_cnt >= ffba_pkg::MaxBlocks) begin
            r.status = ffba_pkg::ST_FULL;
          end else if (nt[33:32] != 2'b0) begin
            r.status = ffba_pkg::ST_OVERFLOW;
          end else begin
            blk_start[blk_cnt] = top_addr[31:0];
            blk_size[blk_cnt] = it.alloc_size;
            blk_free[blk_cnt] = 0;
            blk_cnt++;
            r.result_address = top_addr[31:0] + 32'(hdr_reg);
            r.status = ffba_pkg::ST_NEW;
            top_addr = nt[32:0];
          end
        end
      end else if (it.user_address == 0) begin
        r.status = ffba_pkg::ST_NULL;
      end else begin
        head = it.user_address - 32'(hdr_reg);
        for (i = 0; i < blk_cnt; i++)
          if (blk_start[i] == head) break;
        if (i >= blk_cnt) begin
          r.status = ffba_pkg::ST_NOT_FOUND;
        end else begin
          blk_free[i] = 1;
          if (i + 1 < blk_cnt && blk_free[i+1]) begin
            merged = 34'(blk_size[i]) + 34'(hdr_reg) + 34'(blk_size[i+1]);
            blk_size[i] = (merged[33:32] != 2'b0) ? 32'hFFFF_FFFF : merged[31:0];
            for (int j = i + 1; j + 1 < blk_cnt; j++) begin
              blk_start[j] = blk_start[j+1];
              blk_size[j] = blk_size[j+1];
              blk_free[j] = blk_free[j+1];
            end
            blk_cnt--;
          end
          r.status = ffba_pkg::ST_FREED;
        end
      end
      pending_q.push_back(r);
    endfunction

    function void check_result(ffba_pkg::out_item_t got);
      ffba_pkg::out_item_t exp_r;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result addr=%h status=%0d",
                   got.result_address, got.status);
        return;
      end
      exp_r = pending_q.pop_front();
      checked++;
      status_seen[exp_r.status]++;
      if (got.result_address !== exp_r.result_address || got.status !== exp_r.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d exp addr=%h st=%0d got addr=%h st=%0d",
                   checked, exp_r.result_address, exp_r.status,
                   got.result_address, got.status);
      end
    endfunction

    // Pick the user address of any table entry, free or not, or 0 if empty
    function bit [31:0] live_address();
      if (blk_cnt == 0) return 32'd0;
      return blk_start[$urandom_range(blk_cnt - 1)] + 32'(hdr_reg);
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  ffba_pkg::in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  ffba_pkg::out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [31:0] cfg_index;
  logic [31:0] cfg_data;

  alloc_scoreboard heap_sb;
  bit stim_done;
  bit rx_steady;
  ffba_pkg::in_item_t bits_or, bits_and;

  first_fit_block_allocator_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Send one item with a random lead-in gap; valid is dropped only for a gap
  task automatic send_item(ffba_pkg::in_item_t it);
    int gap;
    gap = rx_steady ? 0 : $urandom_range(15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    bits_or |= it;
    bits_and &= it;
    do @(posedge clk); while (!in_ready);
    heap_sb.note_item(it);
    @(negedge clk);
  endtask

  task automatic write_cfg(bit [31:0] idx, bit [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    heap_sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (heap_sb.pending_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic send_alloc(bit [31:0] sz);
    ffba_pkg::in_item_t it;
    it = '0;
    it.action = ffba_pkg::ACT_ALLOC;
    it.alloc_size = sz;
    it.user_address = $urandom();
    send_item(it);
  endtask

  task automatic send_free(bit [31:0] ua);
    ffba_pkg::in_item_t it;
    it = '0;
    it.action = ffba_pkg::ACT_FREE;
    it.user_address = ua;
    it.alloc_size = $urandom();
    send_item(it);
  endtask

  // Result side: random stall per item, sample at rising edge
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = rx_steady ? 0 : $urandom_range(15);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      heap_sb.check_result(out_data);
    end
  end

  // Random phase: mostly well-formed alloc/free mixes, some noise
  task automatic random_phase(int n);
    int sel;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      if (k % 60 == 30) rx_steady = ~rx_steady;
      if (sel < 45)
        send_alloc(($urandom_range(3) == 0) ? $urandom() : $urandom_range(300));
      else if (sel < 85)
        send_free(heap_sb.live_address());
      else if (sel < 90)
        send_free(32'd0);
      else
        send_free($urandom());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    stim_done = 0;
    rx_steady = 0;
    bits_or = '0;
    bits_and = '1;
    heap_sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reuse, merge, double free, null, unknown, overflow
    send_alloc(32'd0);
    send_alloc(32'd100);
    send_alloc(32'd50);
    send_alloc(32'd8);
    send_free(heap_sb.blk_start[1] + 12);
    send_free(heap_sb.blk_start[1] + 12);
    send_free(heap_sb.blk_start[0] + 12);
    send_alloc(32'd90);
    send_alloc(32'd1000);
    send_free(32'd0);
    send_free(32'hFFFF_FFFF);
    send_free(32'd5);
    send_alloc(32'hFFFF_FFFF);
    send_alloc(32'hFFEF_FFF0);
    wait_drained();

    // Header change mid-table, then fill table to trigger full
    write_cfg(32'(ffba_pkg::REG_HEADER), 32'd1);
    write_cfg(32'(ffba_pkg::REG_HEAP_BASE), 32'h1234_5678);
    for (int k = 0; k < ffba_pkg::MaxBlocks; k++) send_alloc($urandom_range(4));
    send_alloc(32'd10_000);
    send_free(heap_sb.live_address());
    wait_drained();
    write_cfg(32'd7, 32'hDEAD_BEEF);
    write_cfg(32'(ffba_pkg::REG_HEADER), 32'd255);
    random_phase(130);
    wait_drained();
    write_cfg(32'(ffba_pkg::REG_HEADER), 32'd12);
    random_phase(130);
    wait_drained();

    // Fresh heap can't be made without reset; empty table needs all merged,
    // so only the no-effect base write on a non-empty table is shown here.
    write_cfg(32'(ffba_pkg::REG_HEAP_BASE), 32'h0000_0000);
    write_cfg(32'(ffba_pkg::REG_HEADER), 32'd3);
    random_phase(160);
    wait_drained();
    stim_done = 1;
  end

  // End of run
  initial begin
    wait (stim_done);
    $display("Covered %0d results: reused %0d new %0d freed %0d null %0d",
             heap_sb.checked, heap_sb.status_seen[0], heap_sb.status_seen[1],
             heap_sb.status_seen[2], heap_sb.status_seen[3]);
    $display("  full %0d overflow %0d not found %0d; input bits toggled: %0b",
             heap_sb.status_seen[4], heap_sb.status_seen[5],
             heap_sb.status_seen[6], &(bits_or & ~bits_and));
    if (heap_sb.mismatches == 0 && heap_sb.pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
